// ===== rtl/core/gdu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gregorian date unit package
// Field widths, month codes, divider constants and the calendar functions
// shared by the date unit and its parts.
// ----------------------------------------------------------------------------
package gdu_pkg;

    localparam int unsigned DAY_W  = 5;
    localparam int unsigned MON_W  = 4;
    localparam int unsigned YEAR_W = 14;
    localparam int unsigned WDAY_W = 3;

    localparam logic [MON_W-1:0] MON_JAN = 4'd1;
    localparam logic [MON_W-1:0] MON_FEB = 4'd2;
    localparam logic [MON_W-1:0] MON_MAR = 4'd3;
    localparam logic [MON_W-1:0] MON_APR = 4'd4;
    localparam logic [MON_W-1:0] MON_MAY = 4'd5;
    localparam logic [MON_W-1:0] MON_JUN = 4'd6;
    localparam logic [MON_W-1:0] MON_JUL = 4'd7;
    localparam logic [MON_W-1:0] MON_AUG = 4'd8;
    localparam logic [MON_W-1:0] MON_SEP = 4'd9;
    localparam logic [MON_W-1:0] MON_OCT = 4'd10;
    localparam logic [MON_W-1:0] MON_NOV = 4'd11;
    localparam logic [MON_W-1:0] MON_DEC = 4'd12;

    localparam logic [DAY_W-1:0] DAY_FIRST = 5'd1;
    localparam logic [DAY_W-1:0] DAY_LONG  = 5'd31;
    localparam logic [DAY_W-1:0] DAY_SHORT = 5'd30;
    localparam logic [DAY_W-1:0] DAY_FEB   = 5'd28;
    localparam logic [DAY_W-1:0] DAY_FEB_L = 5'd29;

    localparam int unsigned C_HUNDRED   = 100;
    localparam int unsigned C_WEEK      = 7;
    localparam int unsigned C_RECIP_100 = 5243;
    localparam int unsigned C_SHIFT_100 = 19;
    localparam int unsigned C_RECIP_7   = 18725;
    localparam int unsigned C_SHIFT_7   = 17;
    localparam int unsigned PROD100_W   = 27;
    localparam int unsigned PROD7_W     = 29;
    localparam int unsigned Q100_W      = 8;
    localparam int unsigned Q7_W        = 12;
    localparam int unsigned SUM_W       = 15;
    localparam int unsigned MMT_W       = 5;

    typedef struct packed {
        logic [DAY_W-1:0]  in_day;
        logic [MON_W-1:0]  in_month;
        logic [YEAR_W-1:0] in_year;
    } t_gdu_req;

    typedef struct packed {
        logic              date_ok;
        logic [WDAY_W-1:0] weekday;
        logic [DAY_W-1:0]  next_day;
        logic [MON_W-1:0]  next_month;
        logic [YEAR_W-1:0] next_year;
        logic [DAY_W-1:0]  prev_day;
        logic [MON_W-1:0]  prev_month;
        logic [YEAR_W-1:0] prev_year;
    } t_gdu_rsp;

    typedef struct packed {
        logic [DAY_W-1:0]  day;
        logic [MON_W-1:0]  month;
        logic [YEAR_W-1:0] year;
    } t_date;

    function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        case (m)
            MON_JAN, MON_MAR, MON_MAY, MON_JUL, MON_AUG, MON_OCT, MON_DEC: begin
                len = DAY_LONG;
            end
            MON_FEB: begin
                len = leap ? DAY_FEB_L : DAY_FEB;
            end
            default: begin
                len = DAY_SHORT;
            end
        endcase
        return len;
    endfunction

    // Month term of the weekday sum, with January and February counted as
    // the eleventh and twelfth months of the year before.
    function automatic logic [MMT_W-1:0] month_term(input logic [MON_W-1:0] m);
        logic [MMT_W-1:0] t;
        case (m)
            MON_JAN: t = 5'd28;
            MON_FEB: t = 5'd31;
            MON_MAR: t = 5'd2;
            MON_APR: t = 5'd5;
            MON_MAY: t = 5'd7;
            MON_JUN: t = 5'd10;
            MON_JUL: t = 5'd12;
            MON_AUG: t = 5'd15;
            MON_SEP: t = 5'd18;
            MON_OCT: t = 5'd20;
            MON_NOV: t = 5'd23;
            MON_DEC: t = 5'd25;
            default: t = '0;
        endcase
        return t;
    endfunction

endpackage

// ===== rtl/core/gdu_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gregorian date unit channels
// Request and response channels with valid/ready handshake and payload.
// ----------------------------------------------------------------------------
interface gdu_req_if;
    import gdu_pkg::*;

    logic     valid;
    logic     ready;
    t_gdu_req data;

    modport src (output valid, output data, input ready);
    modport snk (input valid, input data, output ready);
endinterface

interface gdu_rsp_if;
    import gdu_pkg::*;

    logic     valid;
    logic     ready;
    t_gdu_rsp data;

    modport src (output valid, output data, input ready);
    modport snk (input valid, input data, output ready);
endinterface

// ===== rtl/core/gregorian_date_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gregorian date unit
// Checks a raw date and gives its weekday, following date and preceding date.
// ----------------------------------------------------------------------------
// A date request enters on i_req (day, month, year) and one response leaves
// on o_rsp for each request, in order. The response carries date_ok, the
// weekday (0 is Sunday) and the following and preceding dates; for an
// invalid date every field is zero.
// The work runs through a five-stage pipeline: a request is registered in
// stage 0 and moves through stages 1 to 4, whose register drives o_rsp.
// While o_rsp is not stalled a request can be taken in every cycle, so the
// sustained rate is one date per cycle; the depth is set by the two reciprocal
// multipliers (year by 100, weekday sum by 7), each followed by a register.
// Each stage holds its own valid bit. When o_rsp is stalled the full stages
// hold their contents, while empty stages further up still fill, so i_req
// stays ready until the pipeline is full. Nothing is dropped or repeated.
// Reset clears every valid bit; the pipeline is then empty and ready.
// ----------------------------------------------------------------------------
module gregorian_date_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    gdu_req_if.snk        i_req,
    gdu_rsp_if.src        o_rsp
);
    import gdu_pkg::*;

    localparam int unsigned STAGES = 5;

    logic [STAGES-1:0] r_v;
    logic [STAGES-1:0] n_ld;

    // Stage 0
    t_date               r0_date;
    logic [Q100_W-1:0]   r0_q100;
    logic [PROD100_W-1:0] n_prod100;

    // Stage 1
    t_date               r1_date;
    logic                r1_ok;
    logic                r1_leap;
    logic [DAY_W-1:0]    r1_mlen;
    logic [SUM_W-1:0]    r1_part;
    logic [Q100_W-1:0]   r1_yyq;
    logic [YEAR_W-1:0]   n_rem100;
    logic                n_z100;
    logic                n_leap;
    logic                n_early;
    logic [YEAR_W-1:0]   n_yy;
    logic [Q100_W-1:0]   n_yyq;
    logic [DAY_W-1:0]    n_mlen;
    logic                n_ok;
    logic [SUM_W-1:0]    n_part;

    // Stage 2
    logic                r2_ok;
    logic [SUM_W-1:0]    r2_sum;
    t_date               r2_next;
    t_date               r2_prev;
    t_date               n_next;
    t_date               n_prev;
    logic [SUM_W-1:0]    n_sum;

    // Stage 3
    logic                r3_ok;
    logic [SUM_W-1:0]    r3_sum;
    logic [Q7_W-1:0]     r3_q7;
    t_date               r3_next;
    t_date               r3_prev;
    logic [PROD7_W-1:0]  n_prod7;

    // Stage 4
    t_gdu_rsp            r4_rsp;
    logic [SUM_W-1:0]    n_rem7;
    t_gdu_rsp            n_rsp;

    always_comb begin
        n_ld[STAGES-1] = !r_v[STAGES-1] || o_rsp.ready;
        n_ld[3] = !r_v[3] || n_ld[4];
        n_ld[2] = !r_v[2] || n_ld[3];
        n_ld[1] = !r_v[1] || n_ld[2];
        n_ld[0] = !r_v[0] || n_ld[1];
    end

    assign i_req.ready = n_ld[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (n_ld[0]) begin
                r_v[0] <= i_req.valid;
            end
            if (n_ld[1]) begin
                r_v[1] <= r_v[0];
            end
            if (n_ld[2]) begin
                r_v[2] <= r_v[1];
            end
            if (n_ld[3]) begin
                r_v[3] <= r_v[2];
            end
            if (n_ld[4]) begin
                r_v[4] <= r_v[3];
            end
        end
    end

    // Stage 0: year divided by 100 through its reciprocal.
    assign n_prod100 = PROD100_W'(i_req.data.in_year) * PROD100_W'(C_RECIP_100);

    always_ff @(posedge i_clk) begin
        if (n_ld[0]) begin
            r0_date.day   <= i_req.data.in_day;
            r0_date.month <= i_req.data.in_month;
            r0_date.year  <= i_req.data.in_year;
            r0_q100       <= n_prod100[C_SHIFT_100 +: Q100_W];
        end
    end

    // Stage 1: leap rule, month length, validity and the first partial sum.
    always_comb begin
        n_rem100 = r0_date.year - YEAR_W'(r0_q100) * YEAR_W'(C_HUNDRED);
        n_z100   = (n_rem100 == '0);
        n_leap   = (n_z100 && (r0_q100[1:0] == 2'b00)) ||
                   (!n_z100 && (r0_date.year[1:0] == 2'b00));
        n_early  = r0_date.month inside {MON_JAN, MON_FEB};
        n_yy     = r0_date.year - YEAR_W'(n_early);
        n_yyq    = r0_q100 - Q100_W'(n_early && n_z100);
        n_mlen   = month_len(r0_date.month, n_leap);
        n_ok     = (r0_date.year != '0) && (r0_date.month >= MON_JAN) &&
                   (r0_date.month <= MON_DEC) && (r0_date.day != '0) &&
                   (r0_date.day <= n_mlen);
        n_part   = SUM_W'(r0_date.day) + SUM_W'(n_yy) + SUM_W'(n_yy >> 2) +
                   SUM_W'(month_term(r0_date.month));
    end

    always_ff @(posedge i_clk) begin
        if (n_ld[1]) begin
            r1_date <= r0_date;
            r1_ok   <= n_ok;
            r1_leap <= n_leap;
            r1_mlen <= n_mlen;
            r1_part <= n_part;
            r1_yyq  <= n_yyq;
        end
    end

    // Stage 2: century terms of the weekday sum and the day stepping.
    assign n_sum = r1_part - SUM_W'(r1_yyq) + SUM_W'(r1_yyq >> 2);

    gdu_step u_step (
        .i_cur  (r1_date),
        .i_mlen (r1_mlen),
        .i_leap (r1_leap),
        .i_ok   (r1_ok),
        .o_next (n_next),
        .o_prev (n_prev)
    );

    always_ff @(posedge i_clk) begin
        if (n_ld[2]) begin
            r2_ok   <= r1_ok;
            r2_sum  <= n_sum;
            r2_next <= n_next;
            r2_prev <= n_prev;
        end
    end

    // Stage 3: weekday sum divided by 7 through its reciprocal.
    assign n_prod7 = PROD7_W'(r2_sum) * PROD7_W'(C_RECIP_7);

    always_ff @(posedge i_clk) begin
        if (n_ld[3]) begin
            r3_ok   <= r2_ok;
            r3_sum  <= r2_sum;
            r3_q7   <= n_prod7[C_SHIFT_7 +: Q7_W];
            r3_next <= r2_next;
            r3_prev <= r2_prev;
        end
    end

    // Stage 4: remainder and output register.
    always_comb begin
        n_rem7           = r3_sum - SUM_W'(r3_q7) * SUM_W'(C_WEEK);
        n_rsp.date_ok    = r3_ok;
        n_rsp.weekday    = r3_ok ? n_rem7[WDAY_W-1:0] : '0;
        n_rsp.next_day   = r3_next.day;
        n_rsp.next_month = r3_next.month;
        n_rsp.next_year  = r3_next.year;
        n_rsp.prev_day   = r3_prev.day;
        n_rsp.prev_month = r3_prev.month;
        n_rsp.prev_year  = r3_prev.year;
    end

    always_ff @(posedge i_clk) begin
        if (n_ld[4]) begin
            r4_rsp <= n_rsp;
        end
    end

    assign o_rsp.valid = r_v[STAGES-1];
    assign o_rsp.data  = r4_rsp;

endmodule

// ===== rtl/core/gdu_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gregorian date unit: day stepper
// Forms the following and preceding dates of a checked date, with month and
// year roll-over; both are zero when the date is invalid.
// ----------------------------------------------------------------------------
module gdu_step (
    input  gdu_pkg::t_date              i_cur,
    input  logic [gdu_pkg::DAY_W-1:0]   i_mlen,
    input  logic                        i_leap,
    input  logic                        i_ok,
    output gdu_pkg::t_date              o_next,
    output gdu_pkg::t_date              o_prev
);
    import gdu_pkg::*;

    t_date            n_next;
    t_date            n_prev;
    logic [MON_W-1:0] n_pm;

    always_comb begin
        n_next = i_cur;
        n_prev = i_cur;
        n_pm   = i_cur.month - MON_JAN;
        if (i_cur.day == i_mlen) begin
            n_next.day = DAY_FIRST;
            if (i_cur.month == MON_DEC) begin
                n_next.month = MON_JAN;
                n_next.year  = i_cur.year + YEAR_W'(1);
            end else begin
                n_next.month = i_cur.month + MON_W'(1);
            end
        end else begin
            n_next.day = i_cur.day + DAY_W'(1);
        end
        if (i_cur.day == DAY_FIRST) begin
            if (i_cur.month == MON_JAN) begin
                n_prev.month = MON_DEC;
                n_prev.year  = i_cur.year - YEAR_W'(1);
                n_prev.day   = DAY_LONG;
            end else begin
                n_prev.month = n_pm;
                n_prev.day   = month_len(n_pm, i_leap);
            end
        end else begin
            n_prev.day = i_cur.day - DAY_W'(1);
        end
        if (!i_ok) begin
            n_next = '0;
            n_prev = '0;
        end
    end

    assign o_next = n_next;
    assign o_prev = n_prev;

endmodule

// ===== rtl/core/gdu_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gregorian date unit checker
// Port-level assertions on the response channel, bound to the top level.
// ----------------------------------------------------------------------------
module gdu_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_rsp_valid,
    input  logic              i_rsp_ready,
    input  gdu_pkg::t_gdu_rsp i_rsp
);
    import gdu_pkg::*;

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp))
        else $error("stalled response changed");

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp.date_ok |->
            i_rsp.weekday == '0 && i_rsp.next_day == '0 && i_rsp.next_month == '0 &&
            i_rsp.next_year == '0 && i_rsp.prev_day == '0 &&
            i_rsp.prev_month == '0 && i_rsp.prev_year == '0)
        else $error("invalid date with non-zero fields");

    a_good_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp.date_ok |->
            i_rsp.weekday < WDAY_W'(C_WEEK) && i_rsp.next_day != '0 &&
            i_rsp.prev_day != '0 && i_rsp.next_month >= MON_JAN &&
            i_rsp.next_month <= MON_DEC && i_rsp.prev_month >= MON_JAN &&
            i_rsp.prev_month <= MON_DEC)
        else $error("valid date with fields out of range");

    a_mid_month: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp.date_ok && i_rsp.next_day != DAY_FIRST &&
            i_rsp.next_day != DAY_W'(2) |->
            i_rsp.next_day == i_rsp.prev_day + DAY_W'(2) &&
            i_rsp.next_month == i_rsp.prev_month &&
            i_rsp.next_year == i_rsp.prev_year)
        else $error("next and previous dates disagree within a month");

endmodule

bind gregorian_date_unit gdu_checker u_gdu_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp       (o_rsp.data)
);
